FILE: hdl/htd_pkg.sv
`default_nettype none

package htd_pkg;

	// Item kinds on the input channel.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// Code bits carried by one data word at most.
	localparam logic [3:0] MAX_BITS = 4'd8;

	typedef struct packed {
		logic       leaf;
		logic [6:0] sym;
		logic [7:0] left;
		logic [7:0] right;
	} htd_entry_t;

	typedef struct packed {
		logic take;
		logic walk;
		logic flush;
	} htd_cmd_t;

	typedef struct packed {
		logic item_valid;
		logic item_kind;
		logic done;
		logic pend_valid;
		logic out_free;
	} htd_stat_t;

endpackage

`default_nettype wire

FILE: hdl/htd_in_if.sv
`default_nettype none

interface htd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] node_index;
	logic       node_is_leaf;
	logic [6:0] node_symbol;
	logic [7:0] left_child;
	logic [7:0] right_child;
	logic [7:0] data_byte;
	logic [3:0] bit_count;

	modport source (
		output valid, kind, node_index, node_is_leaf, node_symbol,
		       left_child, right_child, data_byte, bit_count,
		input  ready
	);

	modport sink (
		input  valid, kind, node_index, node_is_leaf, node_symbol,
		       left_child, right_child, data_byte, bit_count,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/htd_out_if.sv
`default_nettype none

interface htd_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol;
	logic       last;

	modport source (
		output valid, symbol, last,
		input  ready
	);

	modport sink (
		input  valid, symbol, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/htd_ctrl.sv
`default_nettype none

module htd_ctrl
	import htd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  htd_stat_t stat,
	output htd_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.item_valid && stat.item_kind == KIND_DATA) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (stat.done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.take  = (state_q == ST_IDLE);
	assign cmd.walk  = (state_q == ST_WALK);
	assign cmd.flush = (state_q == ST_FLUSH);

endmodule

`default_nettype wire

FILE: hdl/htd_dp.sv
`default_nettype none

module htd_dp
	import htd_pkg::*;
#(
	parameter int NODES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	htd_in_if.sink    items,
	htd_out_if.source results,
	input  htd_cmd_t  cmd,
	output htd_stat_t stat
);

	localparam int         AW        = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [8:0] NODES_LIM = 9'(NODES);

	htd_entry_t node_mem_q [NODES];
	htd_entry_t rd_q;
	htd_entry_t root_q;

	logic [AW-1:0] cur_node_q;
	logic          use_root_q;
	logic          step_q;
	logic [3:0]    cnt_q;
	logic [7:0]    byte_q;
	logic          pend_valid_q;
	logic [6:0]    pend_sym_q;
	logic          out_valid_q;
	logic [6:0]    out_sym_q;
	logic          out_last_q;

	logic          accept;
	logic          accept_data;
	logic          wr_en;
	htd_entry_t    wr_entry;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [3:0]    cnt_sat;

	htd_entry_t    e;
	htd_entry_t    s;
	logic          arrive_leaf;
	logic          have_bit;
	logic [2:0]    bit_idx;
	logic          code_bit;
	logic          do_bit;
	logic [7:0]    child;
	logic          child_ok;
	logic          emit;
	logic [6:0]    emit_sym;
	logic          out_free;
	logic          adv;
	logic          step_read;
	logic          flush_push;
	logic          push;

	assign accept      = cmd.take && items.valid;
	assign accept_data = accept && items.kind == KIND_DATA;
	assign wr_en       = accept && items.kind == KIND_LOAD
	                     && {1'b0, items.node_index} < NODES_LIM;
	assign wr_entry    = '{leaf: items.node_is_leaf, sym: items.node_symbol,
	                       left: items.left_child, right: items.right_child};
	assign cnt_sat     = (items.bit_count > MAX_BITS) ? MAX_BITS : items.bit_count;

	// The entry of the current node comes either from the last table read or,
	// after a return to the root, from the shadow copy of entry 0.
	assign e           = use_root_q ? root_q : rd_q;
	// A freshly reached node that is a leaf is emitted without using a bit.
	assign arrive_leaf = step_q && e.leaf;
	assign have_bit    = (cnt_q != 4'd0);
	assign bit_idx     = 3'(cnt_q - 4'd1);
	assign code_bit    = byte_q[bit_idx];
	assign s           = arrive_leaf ? root_q : e;
	// A leaf root right after a leaf arrival would give a second symbol in
	// the same cycle, so that bit waits until the walk is back at the root.
	assign do_bit      = have_bit && !(arrive_leaf && root_q.leaf);
	assign child       = code_bit ? s.right : s.left;
	assign child_ok    = {1'b0, child} < NODES_LIM;
	assign emit        = arrive_leaf || (do_bit && s.leaf);
	assign emit_sym    = arrive_leaf ? e.sym : s.sym;
	assign out_free    = !out_valid_q || results.ready;
	assign adv         = cmd.walk && (!emit || !pend_valid_q || out_free);
	assign step_read   = do_bit && !s.leaf && child_ok;
	assign flush_push  = cmd.flush && pend_valid_q && out_free;
	assign push        = (adv && emit && pend_valid_q) || flush_push;

	assign rd_en   = accept_data || (adv && step_read);
	assign rd_addr = accept_data ? cur_node_q : child[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem_q[items.node_index[AW-1:0]] <= wr_entry;
		end
		if (rd_en) begin
			rd_q <= node_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && items.node_index == 8'd0) begin
			root_q <= wr_entry;
		end
		if (accept_data) begin
			byte_q <= items.data_byte;
		end
		if (adv && emit) begin
			pend_sym_q <= emit_sym;
		end
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= flush_push;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_node_q   <= '0;
			use_root_q   <= 1'b0;
			step_q       <= 1'b0;
			cnt_q        <= 4'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept_data) begin
				cnt_q      <= cnt_sat;
				use_root_q <= 1'b0;
				step_q     <= 1'b0;
			end else if (adv) begin
				if (do_bit) begin
					cnt_q <= cnt_q - 4'd1;
				end
				if (step_read) begin
					cur_node_q <= child[AW-1:0];
					use_root_q <= 1'b0;
					step_q     <= 1'b1;
				end else if (do_bit || arrive_leaf) begin
					cur_node_q <= '0;
					use_root_q <= 1'b1;
					step_q     <= 1'b0;
				end
			end

			if (adv && emit) begin
				pend_valid_q <= 1'b1;
			end else if (flush_push) begin
				pend_valid_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign items.ready    = cmd.take;
	assign results.valid  = out_valid_q;
	assign results.symbol = out_sym_q;
	assign results.last   = out_last_q;

	assign stat.item_valid = items.valid;
	assign stat.item_kind  = items.kind;
	assign stat.done       = !have_bit && !arrive_leaf;
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;

endmodule

`default_nettype wire

FILE: hdl/huffman_tree_decoder.sv
// Channel   Dir   Word
// items     in    kind, node_index, node_is_leaf, node_symbol, left_child,
//                 right_child, data_byte, bit_count
// results   out   symbol, last
//
// A load word is written into the node table when it is taken. A data word
// is walked in order, if results are not stalled: a first table read, then
// one code bit per step through the single read port of the node table, a
// step to see the bits spent and a step to release the last symbol; a step
// may land on a leaf with no bit left, and a leaf root then waits behind it.
// Reset returns the walk to the root; the node table holds nothing until it
// is loaded. A stalled results channel halts the walk only when a symbol
// must move on; input words are taken again once the data word is finished.
`default_nettype none

module huffman_tree_decoder
	import htd_pkg::*;
#(
	parameter int NODES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	htd_in_if.sink    items,
	htd_out_if.source results
);

	htd_cmd_t  cmd;
	htd_stat_t stat;

	htd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	htd_dp #(
		.NODES (NODES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

`default_nettype wire
